[rtl/kdop_bounds_accumulate_test_macros.svh]
// Assertion shorthands for the k-DOP bounds block.
// Both expect clk and rst_n in scope.
`ifndef KDOP_BOUNDS_ACCUMULATE_TEST_MACROS_SVH
`define KDOP_BOUNDS_ACCUMULATE_TEST_MACROS_SVH

// Property checked at every edge outside reset.
`define KDOP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Trigger at one edge implies consequence at the next.
`define KDOP_ASSERT_NEXT(name, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[rtl/kdop_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kdop_pkg
// Shared widths, constants and types of the k-DOP bounds block.
// ----------------------------------------------------------------------------
package kdop_pkg;

    localparam int NUM_AXES_DEF = 7;
    localparam int MAX_AXES     = 8;

    localparam int KIND_W    = 2;
    localparam int COORD_W   = 16;
    localparam int AXIS_W    = 3;
    localparam int SLAB_W    = 34;
    localparam int PROD_W    = 32;
    localparam int NORM_W    = 48;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [SLAB_W-1:0] SLAB_POS = {1'b0, {(SLAB_W-1){1'b1}}};
    localparam logic signed [SLAB_W-1:0] SLAB_NEG = {1'b1, {(SLAB_W-1){1'b0}}};

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_MERGE = 2'd2,
        KIND_TEST  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MERGE,
        ST_TEST,
        ST_PROJ,
        ST_RESP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch accepted item
        logic clear;      // empty all slabs
        logic merge;      // widen named slab by item interval
        logic test;       // overlap check on named slab
        logic mul_en;     // multiply stage, axis given by mul_idx
        logic upd_en;     // slab update from registered products
        logic resp_load;  // load output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

[rtl/kdop_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kdop_datapath
// Normal registers, item latch, projection unit, slab lanes, output register.
// ----------------------------------------------------------------------------
`include "kdop_bounds_accumulate_test_macros.svh"

module kdop_datapath #(
    parameter int  NUM_AXES = kdop_pkg::NUM_AXES_DEF,
    localparam int IDX_W    = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    cfg_we,
    input  wire  [kdop_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire  [kdop_pkg::NORM_W-1:0]            cfg_wdata,
    input  wire  signed [kdop_pkg::COORD_W-1:0]    vx,
    input  wire  signed [kdop_pkg::COORD_W-1:0]    vy,
    input  wire  signed [kdop_pkg::COORD_W-1:0]    vz,
    input  wire  [kdop_pkg::AXIS_W-1:0]            axis,
    input  wire  signed [kdop_pkg::SLAB_W-1:0]     other_min,
    input  wire  signed [kdop_pkg::SLAB_W-1:0]     other_max,
    input  wire                                    last,
    input  kdop_pkg::cmd_t                         cmd,
    input  wire  [IDX_W-1:0]                       mul_idx,
    output kdop_pkg::stat_t                        status,
    input  wire                                    out_ready,
    output logic                                   out_valid,
    output logic signed [kdop_pkg::SLAB_W-1:0]     slab_lo,
    output logic signed [kdop_pkg::SLAB_W-1:0]     slab_hi,
    output logic                                   hit,
    output logic                                   hit_valid
);

    localparam int SW = kdop_pkg::SLAB_W;
    localparam int CW = kdop_pkg::COORD_W;
    localparam int PW = kdop_pkg::PROD_W;

    // normals
    logic [kdop_pkg::NORM_W-1:0] normal_reg [NUM_AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                normal_reg[i] <= '0;
            end
        end
        else if (cfg_we &&
                 ({1'b0, cfg_index} < (kdop_pkg::CFG_IDX_W+1)'(NUM_AXES)))
        begin
            normal_reg[cfg_index[IDX_W-1:0]] <= cfg_wdata;
        end
    end

    // item latch
    logic signed [CW-1:0]             vx_reg, vy_reg, vz_reg;
    logic [kdop_pkg::AXIS_W-1:0]      axis_reg;
    logic signed [SW-1:0]             omin_reg, omax_reg;
    logic                             last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vx_reg   <= vx;
            vy_reg   <= vy;
            vz_reg   <= vz;
            axis_reg <= axis;
            omin_reg <= other_min;
            omax_reg <= other_max;
            last_reg <= last;
        end
    end

    // projection: three products registered, summed in the update cycle
    logic [kdop_pkg::NORM_W-1:0] nsel;
    logic signed [CW-1:0]        nx, ny, nz;
    logic signed [PW-1:0]        px_reg, py_reg, pz_reg;
    logic [IDX_W-1:0]            pidx_reg;
    logic signed [SW-1:0]        proj;

    assign nsel = normal_reg[mul_idx];
    assign nx   = nsel[15:0];
    assign ny   = nsel[31:16];
    assign nz   = nsel[47:32];

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            px_reg   <= PW'(vx_reg) * PW'(nx);
            py_reg   <= PW'(vy_reg) * PW'(ny);
            pz_reg   <= PW'(vz_reg) * PW'(nz);
            pidx_reg <= mul_idx;
        end
    end

    assign proj = SW'(px_reg) + SW'(py_reg) + SW'(pz_reg);

    // slab lanes
    logic signed [SW-1:0] slab_min_reg [NUM_AXES];
    logic signed [SW-1:0] slab_max_reg [NUM_AXES];
    logic signed [SW-1:0] cand_lo, cand_hi;
    logic                 axis_ok;
    logic [IDX_W-1:0]     axis_idx;

    assign axis_ok  = {1'b0, axis_reg} < (kdop_pkg::AXIS_W+1)'(NUM_AXES);
    assign axis_idx = axis_reg[IDX_W-1:0];
    assign cand_lo  = cmd.upd_en ? proj : omin_reg;
    assign cand_hi  = cmd.upd_en ? proj : omax_reg;

    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_lane
        logic wr;

        assign wr = (cmd.upd_en && (pidx_reg == IDX_W'(g))) ||
                    (cmd.merge && axis_ok && (axis_idx == IDX_W'(g)));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                slab_min_reg[g] <= kdop_pkg::SLAB_POS;
                slab_max_reg[g] <= kdop_pkg::SLAB_NEG;
            end
            else if (cmd.clear)
            begin
                slab_min_reg[g] <= kdop_pkg::SLAB_POS;
                slab_max_reg[g] <= kdop_pkg::SLAB_NEG;
            end
            else if (wr)
            begin
                if (cand_lo < slab_min_reg[g])
                begin
                    slab_min_reg[g] <= cand_lo;
                end
                if (cand_hi > slab_max_reg[g])
                begin
                    slab_max_reg[g] <= cand_hi;
                end
            end
        end
    end

    // readback of the named slab; out-of-range axis reads empty
    logic signed [SW-1:0] rb_lo, rb_hi;
    logic                 ok;

    assign rb_lo = axis_ok ? slab_min_reg[axis_idx] : kdop_pkg::SLAB_POS;
    assign rb_hi = axis_ok ? slab_max_reg[axis_idx] : kdop_pkg::SLAB_NEG;
    assign ok    = !axis_ok || (!(omax_reg < rb_lo) && !(rb_hi < omin_reg));

    // run accumulation
    logic ovl_reg, res_hit_reg, res_hitv_reg;
    logic run;

    assign run = ovl_reg && ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovl_reg      <= 1'b1;
            res_hit_reg  <= 1'b0;
            res_hitv_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            res_hit_reg  <= 1'b0;
            res_hitv_reg <= 1'b0;
        end
        else if (cmd.test)
        begin
            if (last_reg)
            begin
                ovl_reg      <= 1'b1;
                res_hit_reg  <= run;
                res_hitv_reg <= 1'b1;
            end
            else
            begin
                ovl_reg <= run;
            end
        end
    end

    // output register
    logic                 out_valid_reg, hit_reg, hitv_reg;
    logic signed [SW-1:0] lo_reg, hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            hitv_reg      <= 1'b0;
        end
        else if (cmd.resp_load)
        begin
            out_valid_reg <= 1'b1;
            hit_reg       <= res_hit_reg;
            hitv_reg      <= res_hitv_reg;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resp_load)
        begin
            lo_reg <= rb_lo;
            hi_reg <= rb_hi;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign slab_lo         = lo_reg;
    assign slab_hi         = hi_reg;
    assign hit             = hit_reg;
    assign hit_valid       = hitv_reg;

    `KDOP_ASSERT(a_hit_needs_valid, !hit_reg || hitv_reg, "hit set without hit_valid")
    `KDOP_ASSERT_NEXT(a_clear_empties, cmd.clear,
        (slab_min_reg[0] == kdop_pkg::SLAB_POS) && (slab_max_reg[0] == kdop_pkg::SLAB_NEG),
        "slab not empty after clear")
    `KDOP_ASSERT_NEXT(a_out_hold, out_valid_reg && !out_ready, out_valid_reg,
        "result dropped before acceptance")

endmodule
`default_nettype wire

[rtl/kdop_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kdop_ctrl
// Item sequencer: accepts, dispatches by kind, steps axes, hands off result.
// ----------------------------------------------------------------------------
`include "kdop_bounds_accumulate_test_macros.svh"

module kdop_ctrl #(
    parameter int  NUM_AXES = kdop_pkg::NUM_AXES_DEF,
    localparam int IDX_W    = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  [kdop_pkg::KIND_W-1:0]    kind,
    input  kdop_pkg::stat_t                status,
    output kdop_pkg::cmd_t                 cmd,
    output logic [IDX_W-1:0]               mul_idx
);

    localparam int CNT_W = $clog2(NUM_AXES + 1);

    kdop_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kdop_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign mul_idx = cnt_reg[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            kdop_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (kdop_pkg::kind_t'(kind))
                        kdop_pkg::KIND_CLEAR: state_next = kdop_pkg::ST_CLEAR;
                        kdop_pkg::KIND_ADD:   state_next = kdop_pkg::ST_PROJ;
                        kdop_pkg::KIND_MERGE: state_next = kdop_pkg::ST_MERGE;
                        kdop_pkg::KIND_TEST:  state_next = kdop_pkg::ST_TEST;
                        default:              state_next = kdop_pkg::ST_TEST;
                    endcase
                end
            end
            kdop_pkg::ST_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = kdop_pkg::ST_RESP;
            end
            kdop_pkg::ST_MERGE:
            begin
                cmd.merge  = 1'b1;
                state_next = kdop_pkg::ST_RESP;
            end
            kdop_pkg::ST_TEST:
            begin
                cmd.test   = 1'b1;
                state_next = kdop_pkg::ST_RESP;
            end
            kdop_pkg::ST_PROJ:
            begin
                // multiply axis cnt while updating axis cnt-1
                cmd.mul_en = cnt_reg < CNT_W'(NUM_AXES);
                cmd.upd_en = cnt_reg != '0;
                if (cnt_reg == CNT_W'(NUM_AXES))
                begin
                    cnt_next   = '0;
                    state_next = kdop_pkg::ST_RESP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            kdop_pkg::ST_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.resp_load = 1'b1;
                    state_next    = kdop_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kdop_pkg::ST_IDLE;
            end
        endcase
    end

    `KDOP_ASSERT(a_resp_into_free, !cmd.resp_load || status.out_free,
        "result loaded over a pending one")
    `KDOP_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(NUM_AXES), "axis counter overran")
    `KDOP_ASSERT_NEXT(a_add_projects,
        in_valid && in_ready && (kind == kdop_pkg::KIND_ADD),
        state_reg == kdop_pkg::ST_PROJ, "add vertex did not start projection")

endmodule
`default_nettype wire

[rtl/kdop_bounds_accumulate_test.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kdop_bounds_accumulate_test
// k-DOP bounding volume: per-axis min/max slabs with add, merge and test.
// ----------------------------------------------------------------------------
// Keeps one slab [min, max] per axis (NUM_AXES axes, normals written through
// the cfg port as packed nz,ny,nx Q2.14). Each input transaction yields
// exactly one output transaction carrying the named axis's slab after the
// step; a test transaction with last set also carries hit/hit_valid for the
// run. Clear, merge and test pass through their own state (CLEAR, MERGE or
// TEST) and then RESP, which loads the result register; add vertex steps
// through PROJ before RESP instead, because one shared projection unit (three
// 16x16 multipliers, registered, then a three-way sum and compare) visits the
// axes one per cycle, multiply of one axis overlapping the slab update of the
// previous. One item is in work at a time; the next is accepted once the
// current result sits in the output register, even if the consumer has not
// yet taken it. A result that finds the output register still full and not
// being taken waits in RESP until the register frees. Normals must only be
// written while the block is idle.
// ----------------------------------------------------------------------------
module kdop_bounds_accumulate_test #(
    parameter int NUM_AXES = kdop_pkg::NUM_AXES_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,

    // configuration writes: index i is normal_i
    input  wire                                 cfg_we,
    input  wire  [kdop_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [kdop_pkg::NORM_W-1:0]         cfg_wdata,

    // input transaction
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [kdop_pkg::KIND_W-1:0]         kind,
    input  wire  signed [kdop_pkg::COORD_W-1:0] vx,
    input  wire  signed [kdop_pkg::COORD_W-1:0] vy,
    input  wire  signed [kdop_pkg::COORD_W-1:0] vz,
    input  wire  [kdop_pkg::AXIS_W-1:0]         axis,
    input  wire  signed [kdop_pkg::SLAB_W-1:0]  other_min,
    input  wire  signed [kdop_pkg::SLAB_W-1:0]  other_max,
    input  wire                                 last,

    // output transaction
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic signed [kdop_pkg::SLAB_W-1:0]  slab_lo,
    output logic signed [kdop_pkg::SLAB_W-1:0]  slab_hi,
    output logic                                hit,
    output logic                                hit_valid
);

    localparam int IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    kdop_pkg::cmd_t  cmd;
    kdop_pkg::stat_t status;
    logic [IDX_W-1:0] mul_idx;

    // sequencer: dispatch by kind, axis stepping for add vertex
    kdop_ctrl #(
        .NUM_AXES (NUM_AXES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd),
        .mul_idx  (mul_idx)
    );

    // normals, slabs, run flag and the output register
    kdop_datapath #(
        .NUM_AXES (NUM_AXES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .vx        (vx),
        .vy        (vy),
        .vz        (vz),
        .axis      (axis),
        .other_min (other_min),
        .other_max (other_max),
        .last      (last),
        .cmd       (cmd),
        .mul_idx   (mul_idx),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .slab_lo   (slab_lo),
        .slab_hi   (slab_hi),
        .hit       (hit),
        .hit_valid (hit_valid)
    );

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k-DOP bounds block. It predicts every slab
// readback and run hit, and checks each output transaction in order.
// Directed cases come first, then three random phases with different
// handshake idling.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_AXES         = kdop_pkg::NUM_AXES_DEF;
    localparam int PHASE_ITEMS    = 400;   // per random phase
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
    localparam int DRAIN_CYCLES   = 20;

    // One input transaction, as the block sees it.
    typedef struct {
        kdop_pkg::kind_t                     kind;
        logic signed [kdop_pkg::COORD_W-1:0] vx;
        logic signed [kdop_pkg::COORD_W-1:0] vy;
        logic signed [kdop_pkg::COORD_W-1:0] vz;
        logic [kdop_pkg::AXIS_W-1:0]         axis;
        logic signed [kdop_pkg::SLAB_W-1:0]  omin;
        logic signed [kdop_pkg::SLAB_W-1:0]  omax;
        logic                                last;
    } dop_item_t;

    // One output transaction.
    typedef struct {
        logic signed [kdop_pkg::SLAB_W-1:0] lo;
        logic signed [kdop_pkg::SLAB_W-1:0] hi;
        logic                               hit;
        logic                               hit_valid;
    } slab_result_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [kdop_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [kdop_pkg::NORM_W-1:0]         cfg_wdata = '0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    kdop_pkg::kind_t                     kind = kdop_pkg::KIND_CLEAR;
    logic signed [kdop_pkg::COORD_W-1:0] vx = '0;
    logic signed [kdop_pkg::COORD_W-1:0] vy = '0;
    logic signed [kdop_pkg::COORD_W-1:0] vz = '0;
    logic [kdop_pkg::AXIS_W-1:0]         axis = '0;
    logic signed [kdop_pkg::SLAB_W-1:0]  other_min = '0;
    logic signed [kdop_pkg::SLAB_W-1:0]  other_max = '0;
    logic                                last = 1'b0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic signed [kdop_pkg::SLAB_W-1:0]  slab_lo;
    logic signed [kdop_pkg::SLAB_W-1:0]  slab_hi;
    logic                                hit;
    logic                                hit_valid;

    kdop_bounds_accumulate_test u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .vx        (vx),
        .vy        (vy),
        .vz        (vz),
        .axis      (axis),
        .other_min (other_min),
        .other_max (other_max),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .slab_lo   (slab_lo),
        .slab_hi   (slab_hi),
        .hit       (hit),
        .hit_valid (hit_valid)
    );

    // 8 ns clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Bench-side copy of the block state
    // ------------------------------------------------------------------
    logic [kdop_pkg::NORM_W-1:0]        normal_cfg [kdop_pkg::MAX_AXES];  // block holds
    logic [kdop_pkg::NORM_W-1:0]        normal_plan [kdop_pkg::MAX_AXES]; // next set
    logic signed [kdop_pkg::SLAB_W-1:0] bound_min [kdop_pkg::MAX_AXES];
    logic signed [kdop_pkg::SLAB_W-1:0] bound_max [kdop_pkg::MAX_AXES];
    logic                               run_overlap;

    slab_result_t pending_slabs [$];   // expected output transactions, oldest first

    int errors         = 0;
    int sent_count     = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_cycles   = 0;

    // Exact dot product: three 32-bit products summed at 34 bits, Q.14.
    function automatic logic signed [kdop_pkg::SLAB_W-1:0] project_vertex(
        input int                                  a,
        input logic signed [kdop_pkg::COORD_W-1:0] x,
        input logic signed [kdop_pkg::COORD_W-1:0] y,
        input logic signed [kdop_pkg::COORD_W-1:0] z
    );
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        longint             acc;
        nx  = normal_cfg[a][15:0];
        ny  = normal_cfg[a][31:16];
        nz  = normal_cfg[a][47:32];
        acc = longint'(x) * longint'(nx) + longint'(y) * longint'(ny)
            + longint'(z) * longint'(nz);
        return acc[kdop_pkg::SLAB_W-1:0];
    endfunction

    // Applies one accepted transaction to the bench state and returns
    // the output transaction it must produce.
    function automatic slab_result_t advance_bounds(input dop_item_t it);
        slab_result_t                       r;
        logic signed [kdop_pkg::SLAB_W-1:0] proj;
        logic                               in_range;
        logic                               ok;
        in_range    = (it.axis < N_AXES);
        r.hit       = 1'b0;
        r.hit_valid = 1'b0;
        case (it.kind)
            kdop_pkg::KIND_CLEAR:
            begin
                for (int i = 0; i < kdop_pkg::MAX_AXES; i++)
                begin
                    bound_min[i] = kdop_pkg::SLAB_POS;
                    bound_max[i] = kdop_pkg::SLAB_NEG;
                end
            end
            kdop_pkg::KIND_ADD:
            begin
                for (int i = 0; i < N_AXES; i++)
                begin
                    proj = project_vertex(i, it.vx, it.vy, it.vz);
                    if (proj < bound_min[i])
                        bound_min[i] = proj;
                    if (proj > bound_max[i])
                        bound_max[i] = proj;
                end
            end
            kdop_pkg::KIND_MERGE:
            begin
                // each bound widens on its own, so an inverted interval is fine
                if (in_range)
                begin
                    if (it.omin < bound_min[it.axis])
                        bound_min[it.axis] = it.omin;
                    if (it.omax > bound_max[it.axis])
                        bound_max[it.axis] = it.omax;
                end
            end
            default:
            begin
                // touching ends overlap; out-of-range axis always overlaps
                ok = 1'b1;
                if (in_range)
                    ok = !(it.omax < bound_min[it.axis]) && !(bound_max[it.axis] < it.omin);
                run_overlap = run_overlap && ok;
                if (it.last)
                begin
                    r.hit       = run_overlap;
                    r.hit_valid = 1'b1;
                    run_overlap = 1'b1;
                end
            end
        endcase
        r.lo = in_range ? bound_min[it.axis] : kdop_pkg::SLAB_POS;
        r.hi = in_range ? bound_max[it.axis] : kdop_pkg::SLAB_NEG;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------
    function automatic dop_item_t make_item(
        input kdop_pkg::kind_t                    k,
        input logic [kdop_pkg::AXIS_W-1:0]        a,
        input logic signed [kdop_pkg::SLAB_W-1:0] lo,
        input logic signed [kdop_pkg::SLAB_W-1:0] hi,
        input logic                               lst
    );
        dop_item_t it;
        it.kind = k;
        it.vx   = '0;
        it.vy   = '0;
        it.vz   = '0;
        it.axis = a;
        it.omin = lo;
        it.omax = hi;
        it.last = lst;
        return it;
    endfunction

    function automatic dop_item_t make_vertex(
        input logic signed [kdop_pkg::COORD_W-1:0] x,
        input logic signed [kdop_pkg::COORD_W-1:0] y,
        input logic signed [kdop_pkg::COORD_W-1:0] z,
        input logic [kdop_pkg::AXIS_W-1:0]         a,
        input logic                                lst
    );
        dop_item_t it;
        it    = make_item(kdop_pkg::KIND_ADD, a, '0, '0, lst);
        it.vx = x;
        it.vy = y;
        it.vz = z;
        return it;
    endfunction

    function automatic dop_item_t noise_item();
        dop_item_t  it;
        logic [63:0] r;
        it.kind = kdop_pkg::kind_t'($urandom_range(3));
        r       = {$urandom, $urandom};
        it.vx   = r[15:0];
        it.vy   = r[31:16];
        it.vz   = r[47:32];
        it.axis = r[50:48];
        it.last = r[51];
        r       = {$urandom, $urandom};
        it.omin = r[kdop_pkg::SLAB_W-1:0];
        r       = {$urandom, $urandom};
        it.omax = r[kdop_pkg::SLAB_W-1:0];
        return it;
    endfunction

    // Coordinates lean on the extremes now and then.
    function automatic logic signed [kdop_pkg::COORD_W-1:0] rand_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3:       return {{8{r[7]}}, r[7:0]};   // small magnitude
            default: return r[15:0];
        endcase
    endfunction

    // Q2.14 normal component: extremes, unit values or anything.
    function automatic logic [15:0] rand_norm_comp();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h4000;   // +1.0
            3:       return 16'hC000;   // -1.0
            4:       return 16'h0000;
            default: return r[15:0];
        endcase
    endfunction

    function automatic logic [kdop_pkg::NORM_W-1:0] pack_normal(
        input logic [15:0] nx,
        input logic [15:0] ny,
        input logic [15:0] nz
    );
        return {nz, ny, nx};
    endfunction

    // Interval placed against the current slab of axis a: a clean miss on
    // either side, touching either end, or straddling the whole slab.
    function automatic void pick_interval(
        input  logic [kdop_pkg::AXIS_W-1:0]        a,
        output logic signed [kdop_pkg::SLAB_W-1:0] lo,
        output logic signed [kdop_pkg::SLAB_W-1:0] hi
    );
        logic signed [kdop_pkg::SLAB_W-1:0] lo_b;
        logic signed [kdop_pkg::SLAB_W-1:0] hi_b;
        logic signed [kdop_pkg::SLAB_W-1:0] d;
        logic signed [kdop_pkg::SLAB_W-1:0] span;
        lo_b = (a < N_AXES) ? bound_min[a] : -34'sd1000;
        hi_b = (a < N_AXES) ? bound_max[a] : 34'sd1000;
        d    = 34'($urandom_range(0, 3));
        span = 34'($urandom_range(0, 64));
        case ($urandom_range(7))
            0:
            begin
                hi = lo_b - 34'sd1 - d;
                lo = hi - span;
            end
            1:
            begin
                lo = hi_b + 34'sd1 + d;
                hi = lo + span;
            end
            2:
            begin
                hi = lo_b;
                lo = lo_b - span;
            end
            3:
            begin
                lo = hi_b;
                hi = hi_b + span;
            end
            default:
            begin
                lo = lo_b - d;
                hi = hi_b + d;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Present one input transaction and hold it until accepted, then
    // record what it must produce. Valid stays up unless the sender idles.
    task automatic send_item(input dop_item_t it);
        in_valid  <= 1'b1;
        kind      <= it.kind;
        vx        <= it.vx;
        vy        <= it.vy;
        vz        <= it.vz;
        axis      <= it.axis;
        other_min <= it.omin;
        other_max <= it.omax;
        last      <= it.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_slabs.push_back(advance_bounds(it));
        sent_count++;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    // Stop sending and wait until every expected result has come back.
    // Every transaction yields a result, so the block is idle after this.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_slabs.size() != 0)
            @(posedge clk);
    endtask

    // Write all eight normals from normal_plan; only called while idle.
    task automatic program_normals();
        for (int i = 0; i < kdop_pkg::MAX_AXES; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[kdop_pkg::CFG_IDX_W-1:0];
            cfg_wdata <= normal_plan[i];
            @(posedge clk);
            normal_cfg[i] = normal_plan[i];
        end
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: random backpressure and the in-order checker
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic check_field(
        input string       what,
        input logic [63:0] want,
        input logic [63:0] got
    );
        if (want !== got)
        begin
            errors++;
            $display("%0t %s mismatch: expected %h actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        slab_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_slabs.size() == 0)
            begin
                errors++;
                $display("%0t unexpected output transaction: slab %h..%h hit %b/%b",
                         $time, slab_lo, slab_hi, hit, hit_valid);
            end
            else
            begin
                want = pending_slabs.pop_front();
                check_field("slab_lo",   64'(want.lo),        64'(slab_lo));
                check_field("slab_hi",   64'(want.hi),        64'(slab_hi));
                check_field("hit",       64'(want.hit),       64'(hit));
                check_field("hit_valid", 64'(want.hit_valid), 64'(hit_valid));
            end
        end
    end

    // Watchdog: any transaction on either channel, or a config write,
    // counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog: no transaction for %0d cycles", $time, stall_cycles);
            $display("kdop_bounds_accumulate_test verification failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset: normals zero, every slab empty.
    task automatic test_empty_volume();
        // empty slab against the full-range interval: touching ends, so it overlaps
        send_item(make_item(kdop_pkg::KIND_TEST, 3'd0, kdop_pkg::SLAB_NEG,
                            kdop_pkg::SLAB_POS, 1'b1));
        // axis past NUM_AXES: test overlaps, readback is an empty slab
        send_item(make_item(kdop_pkg::KIND_TEST, 3'd7, '0, '0, 1'b1));
        // merge on that axis is dropped
        send_item(make_item(kdop_pkg::KIND_MERGE, 3'd7, -34'sd1, 34'sd1, 1'b0));
        // last on a clear does nothing
        send_item(make_item(kdop_pkg::KIND_CLEAR, 3'd7, '0, '0, 1'b1));
        wait_drained();
    endtask

    // Extreme normals against extreme vertices: the largest products.
    task automatic test_extreme_normals();
        normal_plan[0] = pack_normal(16'h8000, 16'h8000, 16'h8000);
        normal_plan[1] = pack_normal(16'h7FFF, 16'h7FFF, 16'h7FFF);
        normal_plan[2] = pack_normal(16'h4000, 16'h0000, 16'h0000);
        normal_plan[3] = pack_normal(16'h8000, 16'h7FFF, 16'h0001);
        normal_plan[4] = pack_normal(16'h0000, 16'hC000, 16'h0000);
        normal_plan[5] = pack_normal(16'hFFFF, 16'hFFFF, 16'hFFFF);
        normal_plan[6] = pack_normal(16'h0000, 16'h0000, 16'h4000);
        normal_plan[7] = '1;
        program_normals();
        send_item(make_vertex(16'sh8000, 16'sh8000, 16'sh8000, 3'd0, 1'b1));
        send_item(make_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 3'd1, 1'b0));
        send_item(make_vertex(16'sh7FFF, 16'sh8000, 16'sh0000, 3'd3, 1'b0));
        send_item(make_item(kdop_pkg::KIND_TEST, 3'd5, '0, '0, 1'b1));
        wait_drained();
    endtask

    // Merge with the full 34-bit range and with an inverted interval.
    task automatic test_merge_extremes();
        send_item(make_item(kdop_pkg::KIND_CLEAR, 3'd2, '0, '0, 1'b0));
        send_item(make_item(kdop_pkg::KIND_MERGE, 3'd2, kdop_pkg::SLAB_NEG,
                            kdop_pkg::SLAB_POS, 1'b0));
        send_item(make_item(kdop_pkg::KIND_MERGE, 3'd3, 34'sd100, -34'sd100, 1'b0));
        send_item(make_item(kdop_pkg::KIND_MERGE, 3'd3, -34'sd5, 34'sd5, 1'b1));
        wait_drained();
    endtask

    // Overlap edges and run bookkeeping on a slab of [-50, 50].
    task automatic test_overlap_edges();
        send_item(make_item(kdop_pkg::KIND_CLEAR, 3'd0, '0, '0, 1'b0));
        send_item(make_item(kdop_pkg::KIND_MERGE, 3'd0, -34'sd50, 34'sd50, 1'b0));
        // touching at both ends still overlaps
        send_item(make_item(kdop_pkg::KIND_TEST, 3'd0, -34'sd80, -34'sd50, 1'b0));
        send_item(make_item(kdop_pkg::KIND_TEST, 3'd0, 34'sd50, 34'sd90, 1'b1));
        // one miss spoils the run, next run starts fresh
        send_item(make_item(kdop_pkg::KIND_TEST, 3'd0, -34'sd90, -34'sd51, 1'b0));
        send_item(make_item(kdop_pkg::KIND_TEST, 3'd0, '0, '0, 1'b1));
        send_item(make_item(kdop_pkg::KIND_TEST, 3'd0, '0, '0, 1'b1));
        send_item(make_item(kdop_pkg::KIND_TEST, 3'd0, 34'sd51, 34'sd60, 1'b1));
        // a merge with last set neither ends the run nor resets it
        send_item(make_item(kdop_pkg::KIND_TEST, 3'd0, -34'sd90, -34'sd51, 1'b0));
        send_item(make_item(kdop_pkg::KIND_MERGE, 3'd1, '0, '0, 1'b1));
        send_item(make_item(kdop_pkg::KIND_TEST, 3'd0, '0, '0, 1'b1));
        wait_drained();
    endtask

    // Random traffic: fresh normals, then mostly build-then-test sequences
    // (clear, vertices, merges, a test run ending in last) with some noise.
    task automatic test_random_traffic(input int snd_idle, input int rcv_idle);
        int                                 n;
        logic [kdop_pkg::AXIS_W-1:0]        a;
        logic signed [kdop_pkg::SLAB_W-1:0] lo;
        logic signed [kdop_pkg::SLAB_W-1:0] hi;
        for (int i = 0; i < kdop_pkg::MAX_AXES; i++)
            normal_plan[i] = pack_normal(rand_norm_comp(), rand_norm_comp(),
                                         rand_norm_comp());
        program_normals();
        send_idle_pct = snd_idle;
        recv_idle_pct = rcv_idle;
        sent_count    = 0;
        while (sent_count < PHASE_ITEMS)
        begin
            if ($urandom_range(99) < 20)
                send_item(noise_item());
            else
            begin
                if ($urandom_range(3) == 0)
                    send_item(make_item(kdop_pkg::KIND_CLEAR, 3'($urandom_range(7)),
                                        '0, '0, 1'($urandom_range(1))));
                n = $urandom_range(1, 6);
                repeat (n)
                    send_item(make_vertex(rand_coord(), rand_coord(), rand_coord(),
                                          3'($urandom_range(7)), 1'b0));
                n = $urandom_range(0, 2);
                repeat (n)
                begin
                    a = 3'($urandom_range(7));
                    pick_interval(a, lo, hi);
                    send_item(make_item(kdop_pkg::KIND_MERGE, a, lo, hi, 1'b0));
                end
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                begin
                    a = 3'($urandom_range(7));
                    pick_interval(a, lo, hi);
                    send_item(make_item(kdop_pkg::KIND_TEST, a, lo, hi, k == n - 1));
                end
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < kdop_pkg::MAX_AXES; i++)
        begin
            normal_cfg[i] = '0;
            bound_min[i]  = kdop_pkg::SLAB_POS;
            bound_max[i]  = kdop_pkg::SLAB_NEG;
        end
        run_overlap = 1'b1;

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        test_empty_volume();
        test_extreme_normals();
        test_merge_extremes();
        test_overlap_edges();
        test_random_traffic(9, 73);
        test_random_traffic(73, 9);
        test_random_traffic(0, 0);

        // let any stray output transaction show up
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (errors == 0)
            $display("kdop_bounds_accumulate_test verification clean");
        else
            $display("kdop_bounds_accumulate_test verification failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/kdop_pkg.sv
rtl/kdop_datapath.sv
rtl/kdop_ctrl.sv
rtl/kdop_bounds_accumulate_test.sv
tb/sv/tb_top.sv
